[hw/rtl/plps_pkg.sv]
`timescale 1ns / 1ps
package plps_pkg;

  // input coordinates, signed q12.12
  localparam int CW = 24;
  // specular exponent is 2**SHIN_LOG2
  localparam int SHIN_LOG2 = 5;

  // fraction bits of a unit component
  localparam int FRAC = 15;
  // unit vector component, signed q1.15
  localparam int UW = 17;
  // normaliser input width, wide enough for the reflection vector
  localparam int VW = 52;
  // width of a leading-one position in a normaliser input
  localparam int PW = 6;
  // prescaled magnitude width, leading one lands on bit LEAD
  localparam int MTW = 30;
  localparam int LEAD = 29;
  // sum of squares, square root, quotient and dividend widths
  localparam int SUMW = 62;
  localparam int ROOTW = 31;
  localparam int QW = 16;
  localparam int NUMW = 46;
  // dot product of two unit vectors
  localparam int DOTW = 36;
  // color lane width
  localparam int LANEW = 16;

  // normaliser: abs, lead search, shift, square, sum, root, divide, sign
  localparam int NORM_LAT = 5 + ROOTW + QW + 1;
  // accept to result strobe
  localparam int TOTAL_LAT = 2 * NORM_LAT + SHIN_LOG2 + 11;

  localparam logic [LANEW-1:0] ONE_Q15 = LANEW'(1) << FRAC;

  // configuration port
  localparam int ADDR_W = 5;
  localparam int REG_SHIFT = 3;
  localparam int DATA_W = 64;
  localparam int REGW = 48;
  localparam logic [1:0] REG_DIFFUSE = 2'd0;
  localparam logic [1:0] REG_AMBIENT = 2'd1;
  localparam logic [1:0] REG_SPECULAR = 2'd2;
  localparam logic [1:0] REG_MODE = 2'd3;
  localparam logic MODE_BLINN = 1'b1;

  typedef logic signed [UW-1:0] unit_t;
  typedef logic signed [VW-1:0] wvec_t;
  typedef logic signed [DOTW-1:0] dot_t;

  // values that ride alongside the square root
  typedef struct packed {
    logic [2:0][MTW-1:0] m;
    logic [2:0] s;
    logic z;
  } nside_t;

  // positive part of a dot product, rounded to q1.15 and clamped to one
  function automatic logic [LANEW-1:0] amount(input dot_t d);
    logic [DOTW-1:0] a;
    a = (DOTW'($unsigned(d)) + (DOTW'(1) << (FRAC - 1))) >> FRAC;
    if (d <= 0) begin
      amount = '0;
    end else if (a > DOTW'(ONE_Q15)) begin
      amount = ONE_Q15;
    end else begin
      amount = a[LANEW-1:0];
    end
  endfunction

  // rounded q1.15 product of two lanes
  function automatic logic [LANEW:0] q15_mul(input logic [LANEW-1:0] a,
                                             input logic [LANEW-1:0] b);
    logic [2*LANEW:0] pr;
    pr = (2*LANEW+1)'(a) * (2*LANEW+1)'(b) + ((2*LANEW+1)'(1) << (FRAC - 1));
    q15_mul = pr[FRAC+LANEW:FRAC];
  endfunction

endpackage

[hw/rtl/plps_sqrt.sv]
`timescale 1ns / 1ps
module plps_sqrt (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic [plps_pkg::SUMW-1:0]      rad,
  input  plps_pkg::nside_t               in_side,
  output logic                           out_valid,
  output logic [plps_pkg::ROOTW-1:0]     root,
  output plps_pkg::nside_t               out_side
);

  localparam int SW = plps_pkg::SUMW;
  localparam int RW = plps_pkg::ROOTW;
  localparam int TW = plps_pkg::SUMW + 2;

  logic [SW-1:0] s_rem [RW];
  logic [RW-1:0] s_root [RW];
  plps_pkg::nside_t s_side [RW];
  logic s_v [RW];

  // one root bit per stage, most significant first
  genvar k;
  generate
    for (k = 0; k < RW; k++) begin : g_bit
      localparam int B = RW - 1 - k;
      logic [SW-1:0] prem;
      logic [RW-1:0] proot;
      logic [TW-1:0] trial;

      if (k == 0) begin : g_first
        assign prem = rad;
        assign proot = '0;
        always_ff @(posedge clk) begin
          if (rst) begin
            s_v[k] <= 1'b0;
          end else begin
            s_v[k] <= in_valid;
          end
          s_side[k] <= in_side;
        end
      end else begin : g_next
        assign prem = s_rem[k-1];
        assign proot = s_root[k-1];
        always_ff @(posedge clk) begin
          if (rst) begin
            s_v[k] <= 1'b0;
          end else begin
            s_v[k] <= s_v[k-1];
          end
          s_side[k] <= s_side[k-1];
        end
      end

      // (root + 2^B)^2 - root^2
      assign trial = (TW'(proot) << (B + 1)) + (TW'(1) << (2 * B));

      always_ff @(posedge clk) begin
        if (TW'(prem) >= trial) begin
          s_rem[k] <= prem - trial[SW-1:0];
          s_root[k] <= proot | (RW'(1) << B);
        end else begin
          s_rem[k] <= prem;
          s_root[k] <= proot;
        end
      end
    end
  endgenerate

  assign out_valid = s_v[RW-1];
  assign root = s_root[RW-1];
  assign out_side = s_side[RW-1];

endmodule

[hw/rtl/plps_norm.sv]
`timescale 1ns / 1ps
module plps_norm (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  plps_pkg::wvec_t       vin [3],
  output logic                  out_valid,
  output plps_pkg::unit_t       vout [3]
);

  localparam int VW = plps_pkg::VW;
  localparam int PW = plps_pkg::PW;
  localparam int MTW = plps_pkg::MTW;
  localparam int SW = plps_pkg::SUMW;
  localparam int RW = plps_pkg::ROOTW;
  localparam int QW = plps_pkg::QW;
  localparam int NW = plps_pkg::NUMW;
  localparam int UW = plps_pkg::UW;

  // magnitudes and signs
  logic v1;
  logic [VW-1:0] m1 [3];
  logic [2:0] s1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
    for (int i = 0; i < 3; i++) begin
      s1[i] <= vin[i][VW-1];
      m1[i] <= vin[i][VW-1] ? VW'(-vin[i]) : VW'(vin[i]);
    end
  end

  // leading one of the largest magnitude, found on the or of all three
  logic [VW-1:0] orv;
  logic [PW-1:0] lead;

  always_comb begin
    orv = m1[0] | m1[1] | m1[2];
    lead = '0;
    for (int b = 0; b < VW; b++) begin
      if (orv[b]) begin
        lead = PW'(b);
      end
    end
  end

  logic v2;
  logic [VW-1:0] m2 [3];
  logic [2:0] s2;
  logic z2;
  logic [PW-1:0] lead2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    m2 <= m1;
    s2 <= s1;
    z2 <= (orv == '0);
    lead2 <= lead;
  end

  // shift all three together so the largest sits on bit LEAD
  logic [VW-1:0] sh [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (lead2 >= PW'(plps_pkg::LEAD)) begin
        sh[i] = m2[i] >> (lead2 - PW'(plps_pkg::LEAD));
      end else begin
        sh[i] = m2[i] << (PW'(plps_pkg::LEAD) - lead2);
      end
    end
  end

  logic v3;
  logic [MTW-1:0] m3 [3];
  logic [2:0] s3;
  logic z3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    for (int i = 0; i < 3; i++) begin
      m3[i] <= sh[i][MTW-1:0];
    end
    s3 <= s2;
    z3 <= z2;
  end

  // squares
  logic v4;
  logic [2*MTW-1:0] sq4 [3];
  logic [MTW-1:0] m4 [3];
  logic [2:0] s4;
  logic z4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    for (int i = 0; i < 3; i++) begin
      sq4[i] <= (2*MTW)'(m3[i]) * (2*MTW)'(m3[i]);
    end
    m4 <= m3;
    s4 <= s3;
    z4 <= z3;
  end

  // sum of squares
  logic v5;
  logic [SW-1:0] sum5;
  plps_pkg::nside_t side5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
    sum5 <= SW'(sq4[0]) + SW'(sq4[1]) + SW'(sq4[2]);
    for (int i = 0; i < 3; i++) begin
      side5.m[i] <= m4[i];
    end
    side5.s <= s4;
    side5.z <= z4;
  end

  // length
  logic qv;
  logic [RW-1:0] len;
  plps_pkg::nside_t qside;

  plps_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v5),
    .rad       (sum5),
    .in_side   (side5),
    .out_valid (qv),
    .root      (len),
    .out_side  (qside)
  );

  // rounded division of each magnitude by the length, one quotient bit per stage
  logic [NW-1:0] d_rem [QW][3];
  logic [QW-1:0] d_q [QW][3];
  logic [RW-1:0] d_len [QW];
  plps_pkg::nside_t d_side [QW];
  logic d_v [QW];

  genvar k;
  generate
    for (k = 0; k < QW; k++) begin : g_div
      localparam int B = QW - 1 - k;
      logic [NW-1:0] prem [3];
      logic [QW-1:0] pq [3];
      logic [RW-1:0] plen;
      plps_pkg::nside_t pside;
      logic pv;
      logic [NW:0] dsr;

      if (k == 0) begin : g_first
        always_comb begin
          for (int i = 0; i < 3; i++) begin
            prem[i] = (NW'(qside.m[i]) << plps_pkg::FRAC) + NW'(len >> 1);
            pq[i] = '0;
          end
          plen = len;
          pside = qside;
          pv = qv;
        end
      end else begin : g_next
        always_comb begin
          for (int i = 0; i < 3; i++) begin
            prem[i] = d_rem[k-1][i];
            pq[i] = d_q[k-1][i];
          end
          plen = d_len[k-1];
          pside = d_side[k-1];
          pv = d_v[k-1];
        end
      end

      assign dsr = (NW+1)'(plen) << B;

      always_ff @(posedge clk) begin
        if (rst) begin
          d_v[k] <= 1'b0;
        end else begin
          d_v[k] <= pv;
        end
        for (int i = 0; i < 3; i++) begin
          if ({1'b0, prem[i]} >= dsr) begin
            d_rem[k][i] <= prem[i] - dsr[NW-1:0];
            d_q[k][i] <= pq[i] | (QW'(1) << B);
          end else begin
            d_rem[k][i] <= prem[i];
            d_q[k][i] <= pq[i];
          end
        end
        d_len[k] <= plen;
        d_side[k] <= pside;
      end
    end
  endgenerate

  // clamp, restore sign, zero vector stays zero
  logic [QW-1:0] qf [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qf[i] = (d_q[QW-1][i] > plps_pkg::ONE_Q15) ? plps_pkg::ONE_Q15 : d_q[QW-1][i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= d_v[QW-1];
    end
    for (int i = 0; i < 3; i++) begin
      if (d_side[QW-1].z) begin
        vout[i] <= '0;
      end else if (d_side[QW-1].s[i]) begin
        vout[i] <= -UW'(qf[i]);
      end else begin
        vout[i] <= UW'(qf[i]);
      end
    end
  end

endmodule

[hw/rtl/plps_dot.sv]
`timescale 1ns / 1ps
module plps_dot (
  input  logic              clk,
  input  plps_pkg::unit_t   a [3],
  input  plps_pkg::unit_t   b [3],
  output plps_pkg::dot_t    dot
);

  localparam int UW = plps_pkg::UW;
  localparam int DW = plps_pkg::DOTW;

  logic signed [2*UW-1:0] prod [3];

  // products, then their sum
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      prod[i] <= a[i] * b[i];
    end
    dot <= DW'(prod[0]) + DW'(prod[1]) + DW'(prod[2]);
  end

endmodule

[hw/rtl/phong_lighting_shader_core.sv]
`timescale 1ns / 1ps
// Point-light shader, Phong or Blinn-Phong. Takes one fragment per clock and
// never stalls: busy is always low and a new transaction may be started in
// every cycle. Each transaction's color appears on shade_red/green/blue for
// exactly one cycle with done high. Each transaction passes through two
// normaliser pipelines in series, 53 stages each, of which 31 are square-root
// stages and 16 are divide stages; the rest is dot products, the reflection
// or halfway vector, five squaring stages for the shininess power and the
// per-lane color mix. Results come out in order and must be taken when shown.
// Registers sit on the 64-bit APB port at byte addresses 0, 8, 16 and 24; the
// user must write them only while no transaction is in flight, as the block
// itself does not enforce this.
module phong_lighting_shader_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [plps_pkg::CW-1:0]   point_x,
  input  logic signed [plps_pkg::CW-1:0]   point_y,
  input  logic signed [plps_pkg::CW-1:0]   point_z,
  input  logic signed [plps_pkg::CW-1:0]   normal_x,
  input  logic signed [plps_pkg::CW-1:0]   normal_y,
  input  logic signed [plps_pkg::CW-1:0]   normal_z,
  input  logic signed [plps_pkg::CW-1:0]   eye_x,
  input  logic signed [plps_pkg::CW-1:0]   eye_y,
  input  logic signed [plps_pkg::CW-1:0]   eye_z,
  input  logic signed [plps_pkg::CW-1:0]   lamp_x,
  input  logic signed [plps_pkg::CW-1:0]   lamp_y,
  input  logic signed [plps_pkg::CW-1:0]   lamp_z,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [plps_pkg::ADDR_W-1:0]      paddr,
  input  logic [plps_pkg::DATA_W-1:0]      pwdata,
  output logic [plps_pkg::DATA_W-1:0]      prdata,
  output logic                             pready,
  output logic                             done,
  output logic [plps_pkg::LANEW-1:0]       shade_red,
  output logic [plps_pkg::LANEW-1:0]       shade_green,
  output logic [plps_pkg::LANEW-1:0]       shade_blue
);

  localparam int CW = plps_pkg::CW;
  localparam int VW = plps_pkg::VW;
  localparam int UW = plps_pkg::UW;
  localparam int LW = plps_pkg::LANEW;
  localparam int RGW = plps_pkg::REGW;
  localparam int NL = plps_pkg::NORM_LAT;
  localparam int SH = plps_pkg::SHIN_LOG2;
  localparam int DW = plps_pkg::DOTW;
  localparam int FRAC = plps_pkg::FRAC;
  localparam int PRW = DW + 1 + UW;
  localparam int RXW = PRW + 2;

  typedef struct packed {
    logic [2:0][UW-1:0] nv;
    logic [2:0][UW-1:0] ev;
    logic [LW-1:0] dif;
  } dl_t;

  // configuration registers
  logic [RGW-1:0] lt_color;
  logic [RGW-1:0] ambient_factor;
  logic [RGW-1:0] specular_colour;
  logic spec_mode;
  logic [1:0] reg_idx;
  logic wr;

  assign pready = 1'b1;
  assign busy = 1'b0;
  assign reg_idx = paddr[plps_pkg::ADDR_W-1:plps_pkg::REG_SHIFT];
  assign wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      lt_color <= '0;
      ambient_factor <= '0;
      specular_colour <= '0;
      spec_mode <= 1'b0;
    end else if (wr) begin
      case (reg_idx)
        plps_pkg::REG_DIFFUSE: lt_color <= pwdata[RGW-1:0];
        plps_pkg::REG_AMBIENT: ambient_factor <= pwdata[RGW-1:0];
        plps_pkg::REG_SPECULAR: specular_colour <= pwdata[RGW-1:0];
        plps_pkg::REG_MODE: spec_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      plps_pkg::REG_DIFFUSE: prdata = plps_pkg::DATA_W'(lt_color);
      plps_pkg::REG_AMBIENT: prdata = plps_pkg::DATA_W'(ambient_factor);
      plps_pkg::REG_SPECULAR: prdata = plps_pkg::DATA_W'(specular_colour);
      plps_pkg::REG_MODE: prdata = plps_pkg::DATA_W'(spec_mode);
      default: prdata = '0;
    endcase
  end

  // input capture: normal, light and view directions
  logic signed [CW-1:0] pt [3];
  logic signed [CW-1:0] nm [3];
  logic signed [CW-1:0] ey [3];
  logic signed [CW-1:0] lp [3];

  assign pt = '{point_x, point_y, point_z};
  assign nm = '{normal_x, normal_y, normal_z};
  assign ey = '{eye_x, eye_y, eye_z};
  assign lp = '{lamp_x, lamp_y, lamp_z};

  logic a_v;
  plps_pkg::wvec_t a_n [3];
  plps_pkg::wvec_t a_l [3];
  plps_pkg::wvec_t a_e [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else begin
      a_v <= start && !busy;
    end
    for (int i = 0; i < 3; i++) begin
      a_n[i] <= VW'(nm[i]);
      a_l[i] <= VW'(lp[i]) - VW'(pt[i]);
      a_e[i] <= VW'(ey[i]) - VW'(pt[i]);
    end
  end

  // first normalisers
  logic b_v;
  logic nl_v;
  logic ne_v;
  plps_pkg::unit_t nv [3];
  plps_pkg::unit_t lv [3];
  plps_pkg::unit_t ev [3];

  plps_norm u_norm_n (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (a_v),
    .vin       (a_n),
    .out_valid (b_v),
    .vout      (nv)
  );

  plps_norm u_norm_l (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (a_v),
    .vin       (a_l),
    .out_valid (nl_v),
    .vout      (lv)
  );

  plps_norm u_norm_e (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (a_v),
    .vin       (a_e),
    .out_valid (ne_v),
    .vout      (ev)
  );

  // diffuse dot product
  plps_pkg::dot_t dot_nl;

  plps_dot u_dot_nl (
    .clk (clk),
    .a   (nv),
    .b   (lv),
    .dot (dot_nl)
  );

  // halfway vector, carried alongside the dot product
  logic c_v, d_v;
  plps_pkg::unit_t c_nv [3], c_lv [3], c_ev [3];
  plps_pkg::unit_t d_nv [3], d_lv [3], d_ev [3];
  logic signed [UW:0] c_h [3], d_h [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
      d_v <= 1'b0;
    end else begin
      c_v <= b_v;
      d_v <= c_v;
    end
    for (int i = 0; i < 3; i++) begin
      c_h[i] <= (UW+1)'(lv[i]) + (UW+1)'(ev[i]);
      d_h[i] <= c_h[i];
    end
    c_nv <= nv;
    c_lv <= lv;
    c_ev <= ev;
    d_nv <= c_nv;
    d_lv <= c_lv;
    d_ev <= c_ev;
  end

  // diffuse amount and d = N.(-L)
  logic e_v;
  logic [LW-1:0] e_dif;
  logic signed [DW:0] e_dneg;
  plps_pkg::unit_t e_nv [3], e_lv [3], e_ev [3];
  logic signed [UW:0] e_h [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      e_v <= 1'b0;
    end else begin
      e_v <= d_v;
    end
    e_dif <= plps_pkg::amount(dot_nl);
    e_dneg <= -((DW+1)'(dot_nl));
    e_nv <= d_nv;
    e_lv <= d_lv;
    e_ev <= d_ev;
    e_h <= d_h;
  end

  // d * N
  logic f_v;
  logic [LW-1:0] f_dif;
  logic signed [PRW-1:0] f_prod [3];
  plps_pkg::unit_t f_nv [3], f_lv [3], f_ev [3];
  logic signed [UW:0] f_h [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      f_v <= 1'b0;
    end else begin
      f_v <= e_v;
    end
    for (int i = 0; i < 3; i++) begin
      f_prod[i] <= e_dneg * e_nv[i];
    end
    f_dif <= e_dif;
    f_nv <= e_nv;
    f_lv <= e_lv;
    f_ev <= e_ev;
    f_h <= e_h;
  end

  // reflection vector or halfway vector into the second normaliser
  logic signed [RXW-1:0] rr [3];
  logic g_v;
  plps_pkg::wvec_t g_vec [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rr[i] = -(RXW'(f_lv[i]) <<< (2 * FRAC)) - (RXW'(f_prod[i]) <<< 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      g_v <= 1'b0;
    end else begin
      g_v <= f_v;
    end
    for (int i = 0; i < 3; i++) begin
      if (spec_mode == plps_pkg::MODE_BLINN) begin
        g_vec[i] <= VW'(f_h[i]);
      end else begin
        g_vec[i] <= rr[i][VW-1:0];
      end
    end
  end

  // vectors and diffuse amount wait for the second normaliser
  dl_t dl [NL+1];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      dl[0].nv[i] <= f_nv[i];
      dl[0].ev[i] <= f_ev[i];
    end
    dl[0].dif <= f_dif;
    for (int j = 1; j <= NL; j++) begin
      dl[j] <= dl[j-1];
    end
  end

  logic h_v;
  plps_pkg::unit_t hv [3];

  plps_norm u_norm_s (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (g_v),
    .vin       (g_vec),
    .out_valid (h_v),
    .vout      (hv)
  );

  // specular dot product: N.H or E.R
  plps_pkg::unit_t sa [3];
  plps_pkg::dot_t dot_s;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (spec_mode == plps_pkg::MODE_BLINN) begin
        sa[i] = $signed(dl[NL].nv[i]);
      end else begin
        sa[i] = $signed(dl[NL].ev[i]);
      end
    end
  end

  plps_dot u_dot_s (
    .clk (clk),
    .a   (sa),
    .b   (hv),
    .dot (dot_s)
  );

  logic s1_v, s2_v;
  logic [LW-1:0] dif_d [SH+3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      s1_v <= h_v;
      s2_v <= s1_v;
    end
    dif_d[0] <= dl[NL].dif;
    for (int j = 1; j < SH + 3; j++) begin
      dif_d[j] <= dif_d[j-1];
    end
  end

  // specular amount, then repeated squaring
  logic [LW-1:0] pw [SH+1];
  logic pw_v [SH+1];
  logic [LW:0] pw_sq [SH];

  always_ff @(posedge clk) begin
    if (rst) begin
      pw_v[0] <= 1'b0;
    end else begin
      pw_v[0] <= s2_v;
    end
    pw[0] <= plps_pkg::amount(dot_s);
  end

  genvar k;
  generate
    for (k = 0; k < SH; k++) begin : g_pow
      assign pw_sq[k] = plps_pkg::q15_mul(pw[k], pw[k]);
      always_ff @(posedge clk) begin
        if (rst) begin
          pw_v[k+1] <= 1'b0;
        end else begin
          pw_v[k+1] <= pw_v[k];
        end
        pw[k+1] <= pw_sq[k][LW-1:0];
      end
    end
  endgenerate

  // lane products
  logic l1_v;
  logic [LW:0] t_amb [3], t_dif [3], t_spc [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      l1_v <= 1'b0;
    end else begin
      l1_v <= pw_v[SH];
    end
    for (int i = 0; i < 3; i++) begin
      t_amb[i] <= plps_pkg::q15_mul(lt_color[LW*i +: LW], ambient_factor[LW*i +: LW]);
      t_dif[i] <= plps_pkg::q15_mul(lt_color[LW*i +: LW], dif_d[SH+2]);
      t_spc[i] <= plps_pkg::q15_mul(specular_colour[LW*i +: LW], pw[SH]);
    end
  end

  // sum and clamp
  logic [LW+1:0] lsum [3];
  logic [LW-1:0] shade [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lsum[i] = (LW+2)'(t_amb[i]) + (LW+2)'(t_dif[i]) + (LW+2)'(t_spc[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= l1_v;
    end
    for (int i = 0; i < 3; i++) begin
      if (lsum[i] > (LW+2)'(plps_pkg::ONE_Q15)) begin
        shade[i] <= plps_pkg::ONE_Q15;
      end else begin
        shade[i] <= lsum[i][LW-1:0];
      end
    end
  end

  assign shade_red = shade[0];
  assign shade_green = shade[1];
  assign shade_blue = shade[2];

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##(plps_pkg::TOTAL_LAT) done)
    else $error("result strobe missing at fixed latency");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, plps_pkg::TOTAL_LAT))
    else $error("result strobe without a started transaction");

  a_norm_sync: assert property (@(posedge clk) disable iff (rst)
    (nl_v == b_v) && (ne_v == b_v))
    else $error("first normalisers out of step");

  a_spec_range: assert property (@(posedge clk) disable iff (rst)
    pw_v[0] |-> pw[0] <= plps_pkg::ONE_Q15)
    else $error("specular amount above one");

  a_shade_range: assert property (@(posedge clk) disable iff (rst)
    done |-> shade_red <= plps_pkg::ONE_Q15 && shade_green <= plps_pkg::ONE_Q15
             && shade_blue <= plps_pkg::ONE_Q15)
    else $error("shade above one");
`endif

endmodule

[test/tb_phong_lighting_shader_core.sv]
`timescale 1ns / 1ps
module tb_phong_lighting_shader_core;
  import plps_pkg::*;

  typedef struct {
    longint c[3];
  } v3_t;

  typedef struct {
    logic [LANEW-1:0] red;
    logic [LANEW-1:0] green;
    logic [LANEW-1:0] blue;
  } shade_t;

  typedef logic signed [CW-1:0] crd_t [12];

  typedef struct {
    int f[12];
    bit known;
    int red;
    int green;
    int blue;
  } row_t;

  localparam int MAXC = 8388607;
  localparam int MINC = -8388608;
  localparam int ALT5 = 5592405;
  localparam int ALTA = -5592406;

  // directed rows: point, normal, eye, lamp; known colors hold with registers at reset
  localparam int NROWS = 14;
  row_t dir_rows [NROWS] = '{
    '{'{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, 0, 0, 0},
    '{'{MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC},
      1'b1, 0, 0, 0},
    '{'{MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC},
      1'b1, 0, 0, 0},
    '{'{0, 0, 0, 0, 0, 4096, 0, 0, 8192, 0, 0, 8192}, 1'b1, 0, 0, 0},
    '{'{0, 0, 0, 0, 0, -4096, 0, 0, 8192, 0, 0, 8192}, 1'b1, 0, 0, 0},
    '{'{0, 0, 0, 0, 0, 0, 0, 4096, 0, 4096, 4096, 4096}, 1'b1, 0, 0, 0},
    '{'{1000, 2000, 3000, 1, 1, 1, 0, 0, 0, 1000, 2000, 3000}, 1'b1, 0, 0, 0},
    '{'{1000, -2000, 3000, 0, 1, 1, 1000, -2000, 3000, 0, 0, 0}, 1'b1, 0, 0, 0},
    '{'{0, 0, 0, 4096, 0, 0, -4096, 0, 0, 4096, 0, 0}, 1'b1, 0, 0, 0},
    '{'{MAXC, MAXC, MAXC, 5, -3, 7, MINC, MINC, MINC, MINC, MINC, MINC},
      1'b1, 0, 0, 0},
    '{'{MINC, MINC, MINC, MINC, 0, MINC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC},
      1'b1, 0, 0, 0},
    '{'{0, 0, 0, 1, 0, 0, 0, 4096, 0, 0, 1, 0}, 1'b1, 0, 0, 0},
    '{'{100, -200, 300, 0, 0, 4096, -2900, -1200, 5300, 3100, 800, 5300},
      1'b1, 0, 0, 0},
    '{'{ALT5, ALTA, ALT5, ALTA, ALT5, ALTA, ALT5, ALTA, ALT5, ALTA, ALT5, ALTA},
      1'b1, 0, 0, 0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [CW-1:0] point_x = '0, point_y = '0, point_z = '0;
  logic signed [CW-1:0] normal_x = '0, normal_y = '0, normal_z = '0;
  logic signed [CW-1:0] eye_x = '0, eye_y = '0, eye_z = '0;
  logic signed [CW-1:0] lamp_x = '0, lamp_y = '0, lamp_z = '0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;
  logic done;
  logic [LANEW-1:0] shade_red, shade_green, shade_blue;

  // register mirror
  logic [REGW-1:0] diffuse_cfg = '0;
  logic [REGW-1:0] ambient_cfg = '0;
  logic [REGW-1:0] specular_cfg = '0;
  logic blinn_cfg = 1'b0;

  shade_t pending_shades [$];
  int fails = 0;

  phong_lighting_shader_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
    .eye_x(eye_x), .eye_y(eye_y), .eye_z(eye_z),
    .lamp_x(lamp_x), .lamp_y(lamp_y), .lamp_z(lamp_z),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .done(done), .shade_red(shade_red), .shade_green(shade_green),
    .shade_blue(shade_blue)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // integer square root, floor
  function automatic longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // scale to a unit vector in signed q1.15, zero stays zero
  function automatic v3_t unit_vec(input v3_t v);
    longint unsigned m[3];
    longint unsigned big, sum, len, u;
    v3_t o;
    big = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = (v.c[i] < 0) ? longint'(-v.c[i]) : longint'(v.c[i]);
      if (m[i] > big) big = m[i];
    end
    if (big == 0) begin
      for (int i = 0; i < 3; i++) o.c[i] = 0;
      return o;
    end
    while (big >= (64'd1 << 30)) begin
      big = big >> 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
    end
    while (big < (64'd1 << 29)) begin
      big = big << 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
    end
    sum = 0;
    for (int i = 0; i < 3; i++) sum = sum + m[i] * m[i];
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      u = ((m[i] << 15) + (len >> 1)) / len;
      if (u > 32768) u = 32768;
      o.c[i] = (v.c[i] < 0) ? -longint'(u) : longint'(u);
    end
    return o;
  endfunction

  function automatic longint dot_of(input v3_t a, input v3_t b);
    return a.c[0] * b.c[0] + a.c[1] * b.c[1] + a.c[2] * b.c[2];
  endfunction

  function automatic longint unsigned light_amount(input longint d);
    longint unsigned a;
    if (d <= 0) return 0;
    a = (longint'(d) + (64'd1 << 14)) >> 15;
    return (a > 32768) ? 32768 : a;
  endfunction

  function automatic longint unsigned qmul(input longint unsigned a,
                                           input longint unsigned b);
    return (a * b + (64'd1 << 14)) >> 15;
  endfunction

  // expected color of one fragment under the mirrored registers
  function automatic shade_t shade_of(input crd_t crd);
    v3_t p, n, e, l, t, nv, lv, ev, inc;
    longint d;
    longint unsigned dif, spec, dc, sum;
    logic [LANEW-1:0] ln [3];
    shade_t r;
    for (int i = 0; i < 3; i++) begin
      p.c[i] = longint'(crd[i]);
      n.c[i] = longint'(crd[3 + i]);
      e.c[i] = longint'(crd[6 + i]);
      l.c[i] = longint'(crd[9 + i]);
    end
    nv = unit_vec(n);
    for (int i = 0; i < 3; i++) t.c[i] = l.c[i] - p.c[i];
    lv = unit_vec(t);
    for (int i = 0; i < 3; i++) t.c[i] = e.c[i] - p.c[i];
    ev = unit_vec(t);
    dif = light_amount(dot_of(nv, lv));
    if (blinn_cfg == MODE_BLINN) begin
      for (int i = 0; i < 3; i++) t.c[i] = lv.c[i] + ev.c[i];
      spec = light_amount(dot_of(nv, unit_vec(t)));
    end else begin
      for (int i = 0; i < 3; i++) inc.c[i] = -lv.c[i];
      d = dot_of(nv, inc);
      for (int i = 0; i < 3; i++) t.c[i] = inc.c[i] * (64'sd1 <<< 30) - 2 * d * nv.c[i];
      spec = light_amount(dot_of(ev, unit_vec(t)));
    end
    for (int i = 0; i < SHIN_LOG2; i++) spec = qmul(spec, spec);
    for (int k = 0; k < 3; k++) begin
      dc = 64'(diffuse_cfg[16*k +: 16]);
      sum = qmul(dc, 64'(ambient_cfg[16*k +: 16])) + qmul(dc, dif)
          + qmul(64'(specular_cfg[16*k +: 16]), spec);
      if (sum > 32768) sum = 32768;
      ln[k] = sum[LANEW-1:0];
    end
    r.red = ln[0];
    r.green = ln[1];
    r.blue = ln[2];
    return r;
  endfunction

  // one apb write, mirror updated with the low bits that count
  task automatic cfg_write(input logic [1:0] idx, input logic [DATA_W-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(idx) << REG_SHIFT;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_DIFFUSE: diffuse_cfg = val[REGW-1:0];
      REG_AMBIENT: ambient_cfg = val[REGW-1:0];
      REG_SPECULAR: specular_cfg = val[REGW-1:0];
      REG_MODE: blinn_cfg = val[0];
      default: ;
    endcase
  endtask

  // let the pipeline drain before touching registers
  task automatic drain();
    wait (pending_shades.size() == 0);
    repeat (TOTAL_LAT + 4) @(posedge clk);
  endtask

  // present one fragment, with random idle cycles ahead of it
  task automatic send_fragment(input crd_t crd, input int idle_pct,
                               input bit known, input shade_t typed);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    point_x <= crd[0];  point_y <= crd[1];  point_z <= crd[2];
    normal_x <= crd[3]; normal_y <= crd[4]; normal_z <= crd[5];
    eye_x <= crd[6];    eye_y <= crd[7];    eye_z <= crd[8];
    lamp_x <= crd[9];   lamp_y <= crd[10];  lamp_z <= crd[11];
    do @(posedge clk); while (busy);
    pending_shades.push_back(known ? typed : shade_of(crd));
  endtask

  function automatic logic signed [CW-1:0] near_val(input int span);
    return CW'($signed($urandom_range(2 * span)) - span);
  endfunction

  // random fragment: full range, small scene, or near mirror geometry
  function automatic crd_t rand_fragment();
    crd_t c;
    int sel;
    logic signed [CW-1:0] a, b, h;
    sel = $urandom_range(99);
    if (sel < 20) begin
      for (int i = 0; i < 12; i++) c[i] = CW'($urandom());
    end else if (sel < 50) begin
      for (int i = 0; i < 12; i++) c[i] = near_val(16384);
    end else begin
      for (int i = 0; i < 3; i++) c[i] = near_val(8192);
      c[3] = near_val(300);
      c[4] = near_val(300);
      c[5] = CW'($urandom_range(20000, 1));
      a = near_val(12000);
      b = near_val(12000);
      h = CW'($urandom_range(16000, 500));
      c[6] = c[0] - a + near_val(200);
      c[7] = c[1] - b + near_val(200);
      c[8] = c[2] + h + near_val(200);
      c[9] = c[0] + a;
      c[10] = c[1] + b;
      c[11] = c[2] + h;
    end
    return c;
  endfunction

  // one lane setting: full random, one, or small
  function automatic logic [DATA_W-1:0] rand_lanes();
    logic [DATA_W-1:0] v;
    v = {$urandom(), $urandom()};
    case ($urandom_range(2))
      0: ;
      1: v[REGW-1:0] = {3{ONE_Q15}};
      default: v[REGW-1:0] = {3{LANEW'($urandom_range(4096))}};
    endcase
    return v;
  endfunction

  // result check, one transaction per done strobe
  always @(posedge clk) begin
    shade_t want;
    if (!rst && done) begin
      if (pending_shades.size() == 0) begin
        $display("%0t: unexpected transaction %h %h %h", $time,
                 shade_red, shade_green, shade_blue);
        fails++;
      end else begin
        want = pending_shades.pop_front();
        if (shade_red !== want.red) begin
          $display("%0t: shade_red expected %h actual %h", $time, want.red, shade_red);
          fails++;
        end
        if (shade_green !== want.green) begin
          $display("%0t: shade_green expected %h actual %h", $time,
                   want.green, shade_green);
          fails++;
        end
        if (shade_blue !== want.blue) begin
          $display("%0t: shade_blue expected %h actual %h", $time,
                   want.blue, shade_blue);
          fails++;
        end
      end
    end
  end

  // stimulus
  initial begin
    crd_t c;
    shade_t typed;
    int idle;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows twice: registers at reset, then at their extremes
    for (int pass = 0; pass < 2; pass++) begin
      if (pass == 1) begin
        drain();
        cfg_write(REG_DIFFUSE, '1);
        cfg_write(REG_AMBIENT, '1);
        cfg_write(REG_SPECULAR, '1);
        cfg_write(REG_MODE, {DATA_W{1'b1}} ^ 64'(MODE_BLINN));
      end
      for (int r = 0; r < NROWS; r++) begin
        for (int i = 0; i < 12; i++) c[i] = CW'(dir_rows[r].f[i]);
        typed.red = LANEW'(dir_rows[r].red);
        typed.green = LANEW'(dir_rows[r].green);
        typed.blue = LANEW'(dir_rows[r].blue);
        send_fragment(c, 0, dir_rows[r].known && pass == 0, typed);
      end
      start <= 1'b0;
    end

    // random phases, registers changed between them
    for (int ph = 0; ph < 6; ph++) begin
      idle = (ph < 2) ? 18 : (ph < 4) ? 63 : 0;
      drain();
      if (ph == 0) begin
        cfg_write(REG_DIFFUSE, '1);
        cfg_write(REG_AMBIENT, '0);
        cfg_write(REG_SPECULAR, '1);
      end else begin
        cfg_write(REG_DIFFUSE, rand_lanes());
        cfg_write(REG_AMBIENT, rand_lanes());
        cfg_write(REG_SPECULAR, rand_lanes());
      end
      cfg_write(REG_MODE, {$urandom(), $urandom() & ~32'h1} | 64'(ph[0]));
      for (int n = 0; n < 112; n++) begin
        if (ph == 2 && n == 50) begin
          start <= 1'b0;
          wait (pending_shades.size() == 0);
          @(posedge clk);
        end
        send_fragment(rand_fragment(), idle, 1'b0, typed);
      end
      start <= 1'b0;
    end

    wait (pending_shades.size() == 0);
    repeat (TOTAL_LAT + 10) @(posedge clk);
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3000000;
    $display("tb: failure");
    $finish;
  end

endmodule
